@@ design/ntvp_pkg.sv @@
package ntvp_pkg;

   localparam int MAX_SIG_DIGITS = 255;
   localparam int SIG_W          = 8;
   localparam int LEAD_W         = 10;
   localparam int EXPACC_W       = 17;
   localparam int EXPCNT_W       = 5;
   localparam int RDXCNT_W       = 7;
   localparam int EXP_OUT_W      = 16;

   localparam logic signed [LEAD_W-1:0] LEAD_MAX   = 10'sd511;
   localparam logic signed [LEAD_W-1:0] LEAD_MIN   = 10'sh200;
   localparam logic [EXPACC_W-1:0]      EXPACC_MAX = 17'd131071;
   localparam logic [EXPCNT_W-1:0]      EXP_DIGITS_MAX = 5'd18;
   localparam logic [RDXCNT_W-1:0]      HEX_DIGITS_MAX = 7'd16;
   localparam logic [RDXCNT_W-1:0]      BIN_DIGITS_MAX = 7'd64;
   localparam logic [RDXCNT_W-1:0]      OCT_DIGITS_MAX = 7'd22;

   localparam logic [63:0] VALUE_ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SIGNED_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] SIGNED_NEG_LIMIT = 64'h8000_0000_0000_0000;

   localparam logic signed [18:0] EXP_SAT_HI = 19'sd32767;
   localparam logic signed [18:0] EXP_SAT_LO = -19'sd32767;

   typedef enum logic [1:0] {
      ST_INTEGER  = 2'd0,
      ST_FLOAT    = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      PH_START  = 4'd0,
      PH_INT    = 4'd1,
      PH_FRAC   = 4'd2,
      PH_EMARK  = 4'd3,
      PH_EDIG   = 4'd4,
      PH_FROZEN = 4'd5,
      PH_AMP    = 4'd6,
      PH_HEX    = 4'd7,
      PH_BIN    = 4'd8,
      PH_OCT    = 4'd9,
      PH_RDONE  = 4'd10,
      PH_RERR   = 4'd11
   } phase_type;

   typedef struct packed {
      phase_type                   phase;
      logic [63:0]                 accum;
      logic                        minus_seen;
      logic [SIG_W-1:0]            digit_count;
      logic signed [LEAD_W-1:0]    lead_position;
      logic [EXPACC_W-1:0]         exp_accum;
      logic                        exp_minus;
      logic [EXPCNT_W-1:0]         exp_digit_count;
      logic [RDXCNT_W-1:0]         radix_digit_count;
      logic                        octal_lead_high;
      logic                        overflow_flag;
      logic                        frac_sig;
   } parse_state_type;

   localparam parse_state_type PARSE_CLEAR = '{
      phase:             PH_START,
      accum:             64'd0,
      minus_seen:        1'b0,
      digit_count:       '0,
      lead_position:     '0,
      exp_accum:         '0,
      exp_minus:         1'b0,
      exp_digit_count:   '0,
      radix_digit_count: '0,
      octal_lead_high:   1'b0,
      overflow_flag:     1'b0,
      frac_sig:          1'b0
   };

endpackage

@@ design/numeric_text_value_parser.sv @@
// Numeric text parser: turns a string of ASCII characters into an integer
// value, or into the sign, digit count and decimal exponent that a float
// converter needs.
// req_*: one character per word in req_tdata, req_tlast on the final one.
// rsp_*: one result word per string, issued for the word that carried
//   req_tlast. rsp_tuser holds the status (integer, needs float, radix
//   overflow).
// csr_*: signed_result register (csr_data), always ready; write it only
//   while no string is in flight.
// Throughput: one character per cycle while req_tready is high, set by the
// combinational digit multiply-add on the 64-bit accumulator. After its
// last character is taken, a string's final parse state is registered in
// the final-state stage and then forms the registered result word on rsp_tvalid.
// Reset clears the parse state and both result stages and sets
// signed_result to 1. When rsp_tready stays low the result word holds,
// one more finished string waits behind it, and req_tready then drops.
module numeric_text_value_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] ch
   input  logic        req_tlast,  // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,  // [63:0] value, [64] negative,
                                   // [80:65] dec_exponent, [88:81] sig_digits
   output logic [1:0]  rsp_tuser,  // [1:0] status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data    // signed_result
);

   ntvp_pkg::parse_state_type state_ff, state_in;
   ntvp_pkg::parse_state_type upd;
   ntvp_pkg::parse_state_type fin_ff, fin_in;
   logic                      fin_valid_ff, fin_valid_in;
   logic                      signed_ff, signed_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [63:0]               value_ff, value_in;
   ntvp_pkg::status_type      status_ff, status_in;
   logic                      neg_ff, neg_in;
   logic signed [15:0]        exp_ff, exp_in;
   logic [7:0]                sig_ff, sig_in;

   logic        req_fire, rsp_free, fin_move;
   logic [7:0]  ch;
   logic [3:0]  dig;
   logic [3:0]  hex_dig;
   logic        is_dec, is_hex, is_oct, is_bin;
   logic        is_emark;
   logic [67:0] acc_mac;
   logic [20:0] exp_mac;
   logic [ntvp_pkg::RDXCNT_W-1:0] rcnt;
   logic        olh;

   logic signed [18:0] exp_sum;
   logic signed [18:0] exp_part;

   // handshake
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign fin_move   = fin_valid_ff && rsp_free;
   assign req_tready = !fin_valid_ff || rsp_free;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign ch       = req_tdata;
   assign dig      = ch[3:0];
   assign is_dec   = (ch >= "0") && (ch <= "9");
   assign is_oct   = (ch >= "0") && (ch <= "7");
   assign is_bin   = (ch == "0") || (ch == "1");
   assign is_emark = (ch == "D") || (ch == "E") || (ch == "F") ||
                     (ch == "d") || (ch == "e") || (ch == "f");
   assign is_hex   = is_dec || ((ch >= "A") && (ch <= "F")) ||
                     ((ch >= "a") && (ch <= "f"));
   assign hex_dig  = is_dec ? dig : 4'(ch[3:0] + 4'd9);

   // accum * 10 + d, with the carry-out kept for saturation
   assign acc_mac = ({4'd0, state_ff.accum} << 3) + ({4'd0, state_ff.accum} << 1)
                    + {64'd0, dig};
   assign exp_mac = ({4'd0, state_ff.exp_accum} << 3)
                    + ({4'd0, state_ff.exp_accum} << 1) + {17'd0, dig};

   // next parse state for one character
   always_comb begin
      upd  = state_ff;
      rcnt = '0;
      olh  = 1'b0;
      if (state_ff.phase <= ntvp_pkg::PH_EDIG) begin
         if (ch == " " || ch == "\t") begin
            upd = state_ff;
         end else if (ch == "&") begin
            upd.phase = (state_ff.phase == ntvp_pkg::PH_START) ? ntvp_pkg::PH_AMP
                                                               : ntvp_pkg::PH_FROZEN;
         end else if (ch == "-") begin
            if (state_ff.phase == ntvp_pkg::PH_START) begin
               upd.minus_seen = 1'b1;
               upd.phase      = ntvp_pkg::PH_INT;
            end else if (state_ff.phase == ntvp_pkg::PH_EMARK) begin
               upd.exp_minus = 1'b1;
               upd.phase     = ntvp_pkg::PH_EDIG;
            end else begin
               upd.phase = ntvp_pkg::PH_FROZEN;
            end
         end else if (ch == "+") begin
            if (state_ff.phase == ntvp_pkg::PH_START) begin
               upd.phase = ntvp_pkg::PH_INT;
            end else if (state_ff.phase == ntvp_pkg::PH_EMARK) begin
               upd.phase = ntvp_pkg::PH_EDIG;
            end else begin
               upd.phase = ntvp_pkg::PH_FROZEN;
            end
         end else if (ch == ".") begin
            upd.phase = (state_ff.phase > ntvp_pkg::PH_INT) ? ntvp_pkg::PH_FROZEN
                                                            : ntvp_pkg::PH_FRAC;
         end else if (is_emark) begin
            upd.phase = (state_ff.phase > ntvp_pkg::PH_FRAC) ? ntvp_pkg::PH_FROZEN
                                                             : ntvp_pkg::PH_EMARK;
         end else if (is_dec) begin
            if (state_ff.phase <= ntvp_pkg::PH_INT) begin
               upd.phase = ntvp_pkg::PH_INT;
               if (state_ff.digit_count != '0 || dig != 4'd0) begin
                  if (state_ff.lead_position < ntvp_pkg::LEAD_MAX) begin
                     upd.lead_position = state_ff.lead_position + 10'sd1;
                  end
                  if (state_ff.digit_count < ntvp_pkg::SIG_W'(ntvp_pkg::MAX_SIG_DIGITS)) begin
                     upd.digit_count = state_ff.digit_count + 8'd1;
                  end
                  upd.accum = (acc_mac[67:64] != 4'd0) ? ntvp_pkg::VALUE_ALL_ONES
                                                       : acc_mac[63:0];
               end
            end else if (state_ff.phase == ntvp_pkg::PH_FRAC) begin
               if (state_ff.digit_count == '0 && dig == 4'd0 &&
                   state_ff.lead_position > ntvp_pkg::LEAD_MIN) begin
                  upd.lead_position = state_ff.lead_position - 10'sd1;
               end
               if (state_ff.digit_count != '0 || dig != 4'd0) begin
                  if (state_ff.digit_count < ntvp_pkg::SIG_W'(ntvp_pkg::MAX_SIG_DIGITS)) begin
                     upd.digit_count = state_ff.digit_count + 8'd1;
                  end
                  upd.frac_sig = 1'b1;
               end
            end else begin
               upd.phase = ntvp_pkg::PH_EDIG;
               if (state_ff.exp_digit_count != '0 || dig != 4'd0) begin
                  if (state_ff.exp_digit_count >= ntvp_pkg::EXP_DIGITS_MAX) begin
                     upd.phase = ntvp_pkg::PH_FROZEN;
                  end else begin
                     upd.exp_accum = (exp_mac > {4'd0, ntvp_pkg::EXPACC_MAX})
                                     ? ntvp_pkg::EXPACC_MAX : exp_mac[16:0];
                     upd.exp_digit_count = state_ff.exp_digit_count + 5'd1;
                  end
               end
            end
         end else begin
            upd.phase = ntvp_pkg::PH_FROZEN;
         end
      end else begin
         case (state_ff.phase)
            ntvp_pkg::PH_AMP: begin
               if (ch == "H" || ch == "h") begin
                  upd.phase = ntvp_pkg::PH_HEX;
               end else if (ch == "B" || ch == "b") begin
                  upd.phase = ntvp_pkg::PH_BIN;
               end else if (ch == "O" || ch == "o") begin
                  upd.phase = ntvp_pkg::PH_OCT;
               end else begin
                  upd.phase = ntvp_pkg::PH_RDONE;
               end
            end
            ntvp_pkg::PH_HEX: begin
               if (!is_hex) begin
                  upd.phase = ntvp_pkg::PH_RDONE;
               end else begin
                  upd.accum = {state_ff.accum[59:0], hex_dig};
                  rcnt = state_ff.radix_digit_count;
                  if (rcnt != '0 || hex_dig != 4'd0) begin
                     rcnt = rcnt + 7'd1;
                  end
                  upd.radix_digit_count = rcnt;
                  if (rcnt > ntvp_pkg::HEX_DIGITS_MAX) begin
                     upd.overflow_flag = 1'b1;
                     upd.phase         = ntvp_pkg::PH_RERR;
                  end
               end
            end
            ntvp_pkg::PH_BIN: begin
               if (!is_bin) begin
                  upd.phase = ntvp_pkg::PH_RDONE;
               end else begin
                  upd.accum = {state_ff.accum[62:0], dig[0]};
                  rcnt = state_ff.radix_digit_count;
                  if (rcnt != '0 || dig[0]) begin
                     rcnt = rcnt + 7'd1;
                  end
                  upd.radix_digit_count = rcnt;
                  if (rcnt > ntvp_pkg::BIN_DIGITS_MAX) begin
                     upd.overflow_flag = 1'b1;
                     upd.phase         = ntvp_pkg::PH_RERR;
                  end
               end
            end
            ntvp_pkg::PH_OCT: begin
               if (!is_oct) begin
                  upd.phase = ntvp_pkg::PH_RDONE;
               end else begin
                  upd.accum = {state_ff.accum[60:0], dig[2:0]};
                  rcnt = state_ff.radix_digit_count;
                  olh  = state_ff.octal_lead_high;
                  if (rcnt != '0 || dig[2:0] != 3'd0) begin
                     // a leading digit above 1 needs more than one bit of the top digit
                     if (rcnt == '0 && dig[2:0] > 3'd1) begin
                        olh = 1'b1;
                     end
                     rcnt = rcnt + 7'd1;
                  end
                  upd.radix_digit_count = rcnt;
                  upd.octal_lead_high   = olh;
                  if (rcnt >= ntvp_pkg::OCT_DIGITS_MAX &&
                      (rcnt > ntvp_pkg::OCT_DIGITS_MAX || olh)) begin
                     upd.overflow_flag = 1'b1;
                     upd.phase         = ntvp_pkg::PH_RERR;
                  end
               end
            end
            default: begin
               upd = state_ff;
            end
         endcase
      end
   end

   // parse state and final-state stage
   always_comb begin
      state_in     = state_ff;
      fin_in       = fin_ff;
      fin_valid_in = fin_valid_ff;
      if (fin_move) begin
         fin_valid_in = 1'b0;
      end
      if (req_fire) begin
         if (req_tlast) begin
            fin_in       = upd;
            fin_valid_in = 1'b1;
            state_in     = ntvp_pkg::PARSE_CLEAR;
         end else begin
            state_in = upd;
         end
      end
   end

   assign signed_in = (csr_valid && csr_ready) ? csr_data : signed_ff;

   // result word from the final state
   assign exp_part = fin_ff.exp_minus ? -$signed({2'b00, fin_ff.exp_accum})
                                      : $signed({2'b00, fin_ff.exp_accum});
   assign exp_sum  = exp_part + {{9{fin_ff.lead_position[9]}}, fin_ff.lead_position}
                     - 19'sd1;

   always_comb begin
      value_in     = value_ff;
      status_in    = status_ff;
      neg_in       = neg_ff;
      exp_in       = exp_ff;
      sig_in       = sig_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_free) begin
         rsp_valid_in = fin_valid_ff;
      end
      if (fin_move) begin
         value_in  = 64'd0;
         status_in = ntvp_pkg::ST_INTEGER;
         neg_in    = 1'b0;
         exp_in    = 16'sd0;
         sig_in    = 8'd0;
         if (fin_ff.phase >= ntvp_pkg::PH_AMP) begin
            if (fin_ff.overflow_flag) begin
               status_in = ntvp_pkg::ST_OVERFLOW;
            end else begin
               value_in = fin_ff.accum;
            end
         end else begin
            neg_in = fin_ff.minus_seen;
            sig_in = fin_ff.digit_count;
            if (fin_ff.digit_count == '0) begin
               value_in = 64'd0;
            end else if (fin_ff.exp_accum == '0 && !fin_ff.frac_sig) begin
               if (!signed_ff) begin
                  value_in = fin_ff.accum;
               end else if (!fin_ff.minus_seen) begin
                  value_in = (fin_ff.accum > ntvp_pkg::SIGNED_POS_LIMIT)
                             ? ntvp_pkg::SIGNED_POS_LIMIT : fin_ff.accum;
               end else if (fin_ff.accum > ntvp_pkg::SIGNED_NEG_LIMIT) begin
                  value_in = ntvp_pkg::SIGNED_NEG_LIMIT;
               end else begin
                  value_in = 64'd0 - fin_ff.accum;
               end
            end else begin
               status_in = ntvp_pkg::ST_FLOAT;
               if (exp_sum > ntvp_pkg::EXP_SAT_HI) begin
                  exp_in = 16'(ntvp_pkg::EXP_SAT_HI);
               end else if (exp_sum < ntvp_pkg::EXP_SAT_LO) begin
                  exp_in = 16'(ntvp_pkg::EXP_SAT_LO);
               end else begin
                  exp_in = exp_sum[15:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ntvp_pkg::PARSE_CLEAR;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         signed_ff    <= 1'b1;
      end else begin
         state_ff     <= state_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         signed_ff    <= signed_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff    <= fin_in;
      value_ff  <= value_in;
      status_ff <= status_in;
      neg_ff    <= neg_in;
      exp_ff    <= exp_in;
      sig_ff    <= sig_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, sig_ff, exp_ff, neg_ff, value_ff};
   assign rsp_tuser  = status_ff;

endmodule
